/* hw/rtl/snd_pkg.sv */
package snd_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int PERM_W = 8;

	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_NOISE_2D = 2'd1;
	localparam logic [1:0] OP_NOISE_3D = 2'd2;

	localparam logic signed [16:0] F2_Q16     = 17'sd23988;
	localparam logic [13:0]        G2_Q16     = 14'd13849;
	localparam logic [35:0]        RECIP3     = 36'd45812984491;
	localparam logic [17:0]        RECIP6     = 18'd174763;
	localparam logic signed [35:0] SKEW3_BIAS = 36'sd12884901888;
	localparam logic signed [35:0] T_ONE      = 36'sd2147483648;
	localparam logic signed [7:0]  SCALE_2D   = 8'sd70;
	localparam logic signed [7:0]  SCALE_3D   = 8'sd32;

	typedef logic signed [17:0] crd_t;
	typedef logic signed [49:0] contrib_t;

	typedef struct packed {
		logic live;
		logic is3d;
	} corner_ctl_t;

	function automatic logic [15:0] corner_off(input logic is3d, input logic [1:0] k);
		logic [15:0] off;
		case (k)
			2'd0: off = 16'd0;
			2'd1: off = is3d ? 16'd10923 : 16'd13849;
			2'd2: off = is3d ? 16'd21845 : 16'd27699;
			default: off = is3d ? 16'd32768 : 16'd0;
		endcase
		return off;
	endfunction

endpackage

/* hw/rtl/snd_ram.sv */
module snd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* hw/rtl/snd_corner.sv */
module snd_corner (
	input  logic                 clk,
	input  snd_pkg::crd_t        x,
	input  snd_pkg::crd_t        y,
	input  snd_pkg::crd_t        z,
	input  snd_pkg::corner_ctl_t ctl,
	input  logic [7:0]           h,
	output snd_pkg::contrib_t    contrib
);

	import snd_pkg::*;

	function automatic logic [1:0] grad_group(input logic [7:0] hv);
		logic [3:0] ds;
		logic [1:0] grp;
		ds = 4'(hv[7:6]) + 4'(hv[5:4]) + 4'(hv[3:2]);
		case (ds) inside
			4'd0, 4'd3, 4'd6, 4'd9: grp = 2'd0;
			4'd1, 4'd4, 4'd7: grp = 2'd1;
			default: grp = 2'd2;
		endcase
		return grp;
	endfunction

	logic signed [33:0] xe, ye, ze;
	logic [33:0] sqx_s10, sqy_s10, sqz_s10;
	crd_t x_s10, y_s10, z_s10;
	corner_ctl_t ctl_s10;

	logic [35:0] sq_sum;
	logic signed [35:0] tv;
	logic [1:0] grp;
	logic signed [19:0] opa, opb, dot;

	logic dead_s11, dead_s12, dead_s13;
	logic [15:0] u_s11;
	logic signed [19:0] dot_s11, dot_s12, dot_s13;
	logic [30:0] t2_s12;
	logic [14:0] v;
	logic [28:0] t4_s13;

	assign xe = 34'(x);
	assign ye = 34'(y);
	assign ze = 34'(z);

	always_comb begin
		sq_sum = 36'(sqx_s10) + 36'(sqy_s10) + 36'(sqz_s10);
		tv = T_ONE - $signed(sq_sum);
		grp = ctl_s10.is3d ? grad_group(h) : 2'd0;
		opa = (grp == 2'd2) ? 20'(y_s10) : 20'(x_s10);
		opb = (grp == 2'd0) ? 20'(y_s10) : 20'(z_s10);
		dot = (h[0] ? -opa : opa) + (h[1] ? -opb : opb);
		v = t2_s12[30:16];
	end

	always_ff @(posedge clk) begin
		sqx_s10 <= xe * xe;
		sqy_s10 <= ye * ye;
		sqz_s10 <= ze * ze;
		x_s10 <= x;
		y_s10 <= y;
		z_s10 <= z;
		ctl_s10 <= ctl;

		dead_s11 <= tv[35] | ~ctl_s10.live;
		u_s11 <= tv[31:16];
		dot_s11 <= dot;

		dead_s12 <= dead_s11;
		t2_s12 <= u_s11 * u_s11;
		dot_s12 <= dot_s11;

		dead_s13 <= dead_s12;
		t4_s13 <= v * v;
		dot_s13 <= dot_s12;

		contrib <= dead_s13 ? contrib_t'(0) : $signed({1'b0, t4_s13}) * dot_s13;
	end

endmodule

/* hw/rtl/simplex_noise_2d_3d_unit.sv */
// Simplex noise unit, 2D and 3D, signed Q16.16 in, signed Q2.16 out.
// Command channel: a word is taken at a rising edge with start high and busy
// low. busy stays low: one word is taken every cycle, whatever the mix.
// op selects a permutation-table write (table_index, table_value), a 2D
// evaluation (coord_x, coord_y) or a 3D evaluation (coord_x .. coord_z).
// A write gives no result; op 3 is dropped.
// Result channel: result_valid is high for one cycle with noise_value; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// Throughput: one word per cycle. The pipeline stages are skew (two
// multiplier stages), cell split, unskew, simplex ordering, three
// chained permutation lookups (one table copy at the first level and two at
// each later level, two read ports each), per-corner falloff and gradient
// units, a summing tree and the scale/saturate stage. Writes reach each table
// copy at that copy's lookup stage, so words keep their order. Results come
// out in order.
// Reset clears the pipeline valid bits only; the table holds no defined
// contents until written, and every entry a lookup can reach must be written
// before evaluating.
module simplex_noise_2d_3d_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	output logic               result_valid,
	output logic signed [17:0] noise_value
);

	import snd_pkg::*;

	localparam int ST_L1 = 7;
	localparam int ST_L2 = 8;
	localparam int ST_L3 = 9;
	localparam int ST_SCALE = 16;
	localparam int LAT = 17;
	localparam logic signed [18:0] ONE19 = 19'sd65536;

	logic accept;
	logic [LAT:1] vld_q;
	logic [1:0] op_q [1:LAT];
	logic [IDX_W-1:0] tidx_q [1:ST_L3];
	logic [PERM_W-1:0] tval_q [1:ST_L3];

	logic [23:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [23:0] x_s3, y_s3, z_s3, x_s4, y_s4, z_s4;
	logic signed [33:0] sum_s1;
	logic [35:0] v3_s2;
	logic signed [50:0] p2_s2;
	logic [53:0] ph_s3, pl_s3;
	logic [23:0] skew2_s3, skew_s4;
	logic [71:0] tot;
	logic [23:0] cx, cy, cz;
	logic [15:0] fx_s5, fy_s5, fz_s5, fx_s6, fy_s6, fz_s6;
	logic [IDX_W-1:0] ii_s5, jj_s5, kk_s5, ii_s6, jj_s6, kk_s6;
	logic [IDX_W-1:0] ii_s7, jj_s7, kk_s7, ii_s8, jj_s8, ii_s9;
	logic [17:0] w3;
	logic [16:0] w2;
	logic [35:0] prod6;
	logic [30:0] prod2;
	logic [15:0] t_s6;
	crd_t x0_s7, y0_s7, z0_s7, x0_s8, y0_s8, z0_s8;
	logic [2:0] m1, m2, m1_s8, m2_s8;
	logic [2:0] msk [4];
	logic [PERM_W-1:0] l1_rd_a, l1_rd_b;
	logic [PERM_W-1:0] h1 [4];
	logic [IDX_W-1:0] l2_addr [4];
	logic [IDX_W-1:0] l3_addr [4];
	logic [PERM_W-1:0] l2_rd [4];
	logic [PERM_W-1:0] l3_rd [4];
	logic signed [18:0] xs [4];
	logic signed [18:0] ys [4];
	logic signed [18:0] zs [4];
	crd_t xk_s9 [4];
	crd_t yk_s9 [4];
	crd_t zk_s9 [4];
	logic mx_s9 [4];
	corner_ctl_t ctl_s9 [4];
	contrib_t contrib_s14 [4];
	logic signed [50:0] pair0_s15, pair1_s15;
	logic signed [51:0] total_s16;
	logic signed [59:0] scaled_s17;
	logic signed [27:0] rq;
	logic we_l1, we_l2, we_l3;
	logic is3d_s3, is3d_s5, is3d_s7, is3d_s8, is3d_s16;

	assign busy = 1'b0;
	assign accept = start & ~busy;

	assign is3d_s3 = (op_q[3] == OP_NOISE_3D);
	assign is3d_s5 = (op_q[5] == OP_NOISE_3D);
	assign is3d_s7 = (op_q[ST_L1] == OP_NOISE_3D);
	assign is3d_s8 = (op_q[ST_L2] == OP_NOISE_3D);
	assign is3d_s16 = (op_q[ST_SCALE] == OP_NOISE_3D);

	assign we_l1 = vld_q[ST_L1] && (op_q[ST_L1] == OP_WRITE);
	assign we_l2 = vld_q[ST_L2] && (op_q[ST_L2] == OP_WRITE);
	assign we_l3 = vld_q[ST_L3] && (op_q[ST_L3] == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			result_valid <= 1'b0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], accept};
			result_valid <= vld_q[LAT] &&
				((op_q[LAT] == OP_NOISE_2D) || (op_q[LAT] == OP_NOISE_3D));
		end
	end

	always_ff @(posedge clk) begin
		op_q[1] <= op;
		for (int n = 2; n <= LAT; n++) begin
			op_q[n] <= op_q[n-1];
		end
		tidx_q[1] <= table_index;
		tval_q[1] <= table_value;
		for (int n = 2; n <= ST_L3; n++) begin
			tidx_q[n] <= tidx_q[n-1];
			tval_q[n] <= tval_q[n-1];
		end
	end

	always_comb begin
		tot = {ph_s3, 18'b0} + 72'(pl_s3);
		cx = x_s4 + skew_s4;
		cy = y_s4 + skew_s4;
		cz = z_s4 + skew_s4;
		w3 = 18'(fx_s5) + 18'(fy_s5) + 18'(fz_s5);
		w2 = 17'(fx_s5) + 17'(fy_s5);
		prod6 = w3 * RECIP6;
		prod2 = w2 * G2_Q16;
	end

	always_comb begin
		if (is3d_s7) begin
			if (x0_s7 >= y0_s7) begin
				if (y0_s7 >= z0_s7) begin
					m1 = 3'b001;
					m2 = 3'b011;
				end else if (x0_s7 >= z0_s7) begin
					m1 = 3'b001;
					m2 = 3'b101;
				end else begin
					m1 = 3'b100;
					m2 = 3'b101;
				end
			end else begin
				if (y0_s7 < z0_s7) begin
					m1 = 3'b100;
					m2 = 3'b110;
				end else if (x0_s7 < z0_s7) begin
					m1 = 3'b010;
					m2 = 3'b110;
				end else begin
					m1 = 3'b010;
					m2 = 3'b011;
				end
			end
		end else begin
			m1 = (x0_s7 > y0_s7) ? 3'b001 : 3'b010;
			m2 = 3'b011;
		end
	end

	always_comb begin
		msk[0] = 3'b000;
		msk[1] = m1_s8;
		msk[2] = m2_s8;
		msk[3] = 3'b111;
		for (int k = 0; k < 4; k++) begin
			h1[k] = is3d_s8 ? (msk[k][2] ? l1_rd_b : l1_rd_a) : '0;
			l2_addr[k] = jj_s8 + IDX_W'(msk[k][1]) + h1[k];
			xs[k] = 19'(x0_s8) - (msk[k][0] ? ONE19 : 19'sd0)
				+ $signed({3'b000, corner_off(is3d_s8, 2'(k))});
			ys[k] = 19'(y0_s8) - (msk[k][1] ? ONE19 : 19'sd0)
				+ $signed({3'b000, corner_off(is3d_s8, 2'(k))});
			zs[k] = 19'(z0_s8) - (msk[k][2] ? ONE19 : 19'sd0)
				+ $signed({3'b000, corner_off(is3d_s8, 2'(k))});
			l3_addr[k] = ii_s9 + IDX_W'(mx_s9[k]) + l2_rd[k];
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= coord_x[23:0];
		y_s1 <= coord_y[23:0];
		z_s1 <= coord_z[23:0];
		sum_s1 <= (op == OP_NOISE_3D) ? 34'(coord_x) + 34'(coord_y) + 34'(coord_z)
			: 34'(coord_x) + 34'(coord_y);

		x_s2 <= x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		v3_s2 <= 36'(sum_s1) + SKEW3_BIAS;
		p2_s2 <= sum_s1 * F2_Q16;

		x_s3 <= x_s2;
		y_s3 <= y_s2;
		z_s3 <= z_s2;
		ph_s3 <= v3_s2[35:18] * RECIP3;
		pl_s3 <= v3_s2[17:0] * RECIP3;
		skew2_s3 <= p2_s2[39:16];

		x_s4 <= x_s3;
		y_s4 <= y_s3;
		z_s4 <= z_s3;
		skew_s4 <= is3d_s3 ? tot[60:37] : skew2_s3;

		fx_s5 <= cx[15:0];
		fy_s5 <= cy[15:0];
		fz_s5 <= cz[15:0];
		ii_s5 <= cx[23:16];
		jj_s5 <= cy[23:16];
		kk_s5 <= cz[23:16];

		fx_s6 <= fx_s5;
		fy_s6 <= fy_s5;
		fz_s6 <= fz_s5;
		ii_s6 <= ii_s5;
		jj_s6 <= jj_s5;
		kk_s6 <= kk_s5;
		t_s6 <= is3d_s5 ? prod6[35:20] : {1'b0, prod2[30:16]};

		x0_s7 <= $signed({2'b00, fx_s6}) - $signed({2'b00, t_s6});
		y0_s7 <= $signed({2'b00, fy_s6}) - $signed({2'b00, t_s6});
		z0_s7 <= $signed({2'b00, fz_s6}) - $signed({2'b00, t_s6});
		ii_s7 <= ii_s6;
		jj_s7 <= jj_s6;
		kk_s7 <= kk_s6;

		x0_s8 <= x0_s7;
		y0_s8 <= y0_s7;
		z0_s8 <= z0_s7;
		m1_s8 <= m1;
		m2_s8 <= m2;
		ii_s8 <= ii_s7;
		jj_s8 <= jj_s7;

		ii_s9 <= ii_s8;
		for (int k = 0; k < 4; k++) begin
			xk_s9[k] <= xs[k][17:0];
			yk_s9[k] <= ys[k][17:0];
			zk_s9[k] <= is3d_s8 ? zs[k][17:0] : '0;
			mx_s9[k] <= msk[k][0];
			ctl_s9[k].live <= is3d_s8 || (k < 3);
			ctl_s9[k].is3d <= is3d_s8;
		end

		pair0_s15 <= 51'(contrib_s14[0]) + 51'(contrib_s14[1]);
		pair1_s15 <= 51'(contrib_s14[2]) + 51'(contrib_s14[3]);
		total_s16 <= 52'(pair0_s15) + 52'(pair1_s15);
		scaled_s17 <= total_s16 * (is3d_s16 ? SCALE_3D : SCALE_2D);

		if (rq > 28'sd131071) begin
			noise_value <= 18'sd131071;
		end else if (rq < -28'sd131072) begin
			noise_value <= -18'sd131072;
		end else begin
			noise_value <= rq[17:0];
		end
	end

	assign rq = scaled_s17[59:32];

	snd_ram #(
		.WIDTH(PERM_W),
		.DEPTH(TABLE_SIZE)
	) u_ram_l1 (
		.clk(clk),
		.we(we_l1),
		.waddr(tidx_q[ST_L1]),
		.wdata(tval_q[ST_L1]),
		.raddr_a(kk_s7),
		.raddr_b(kk_s7 + IDX_W'(1)),
		.rdata_a(l1_rd_a),
		.rdata_b(l1_rd_b)
	);

	for (genvar j = 0; j < 2; j++) begin : g_lvl
		snd_ram #(
			.WIDTH(PERM_W),
			.DEPTH(TABLE_SIZE)
		) u_ram_l2 (
			.clk(clk),
			.we(we_l2),
			.waddr(tidx_q[ST_L2]),
			.wdata(tval_q[ST_L2]),
			.raddr_a(l2_addr[2*j]),
			.raddr_b(l2_addr[2*j+1]),
			.rdata_a(l2_rd[2*j]),
			.rdata_b(l2_rd[2*j+1])
		);

		snd_ram #(
			.WIDTH(PERM_W),
			.DEPTH(TABLE_SIZE)
		) u_ram_l3 (
			.clk(clk),
			.we(we_l3),
			.waddr(tidx_q[ST_L3]),
			.wdata(tval_q[ST_L3]),
			.raddr_a(l3_addr[2*j]),
			.raddr_b(l3_addr[2*j+1]),
			.rdata_a(l3_rd[2*j]),
			.rdata_b(l3_rd[2*j+1])
		);
	end

	for (genvar k = 0; k < 4; k++) begin : g_corner
		snd_corner u_corner (
			.clk(clk),
			.x(xk_s9[k]),
			.y(yk_s9[k]),
			.z(zk_s9[k]),
			.ctl(ctl_s9[k]),
			.h(l3_rd[k]),
			.contrib(contrib_s14[k])
		);
	end

endmodule

/* test/tb_top.sv */
import snd_pkg::*;

class noise_scoreboard;
	logic signed [17:0] noise_q[$];
	logic [7:0] perm[256];
	int errors;
	int g3x[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
	int g3y[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
	int g3z[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

	function longint fdiv(longint v, longint d);
		longint q;
		q = v / d;
		if ((v % d) != 0 && v < 0)
			q = q - 1;
		return q;
	endfunction

	function longint corner(longint x, longint y, longint z, longint gx, longint gy,
			longint gz);
		longint t;
		longint u;
		longint v;
		t = (64'sd1 <<< 31) - x * x - y * y - z * z;
		if (t < 0)
			return 0;
		u = t >>> 16;
		v = (u * u) >>> 16;
		return v * v * (gx * x + gy * y + gz * z);
	endfunction

	function longint lookup(longint k);
		return longint'(perm[k & 255]);
	endfunction

	function longint noise_2d(longint cx, longint cy);
		longint s, i, j, fx, fy, t, x0, y0, xk, yk, h, sum;
		int si[3];
		int sj[3];
		longint off[3];
		off = '{0, 13849, 27699};
		s = fdiv((cx + cy) * 23988, 65536);
		i = fdiv(cx + s, 65536);
		j = fdiv(cy + s, 65536);
		fx = cx + s - i * 65536;
		fy = cy + s - j * 65536;
		t = fdiv((fx + fy) * 13849, 65536);
		x0 = fx - t;
		y0 = fy - t;
		si = '{0, 0, 1};
		sj = '{0, 0, 1};
		if (x0 > y0)
			si[1] = 1;
		else
			sj[1] = 1;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			xk = x0 - si[k] * 65536 + off[k];
			yk = y0 - sj[k] * 65536 + off[k];
			h = lookup((i & 255) + si[k] + lookup((j & 255) + sj[k])) % 4;
			sum += corner(xk, yk, 0, h[0] ? -1 : 1, h[1] ? -1 : 1, 0);
		end
		return fdiv(sum * 70, 64'sd1 <<< 32);
	endfunction

	function longint noise_3d(longint cx, longint cy, longint cz);
		longint s, i, j, kc, fx, fy, fz, t, x0, y0, z0, xk, yk, zk, h, sum;
		int a[4][3];
		longint off[4];
		off = '{0, 10923, 21845, 32768};
		a = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{1, 1, 1}};
		s = fdiv(cx + cy + cz, 3);
		i = fdiv(cx + s, 65536);
		j = fdiv(cy + s, 65536);
		kc = fdiv(cz + s, 65536);
		fx = cx + s - i * 65536;
		fy = cy + s - j * 65536;
		fz = cz + s - kc * 65536;
		t = fdiv(fx + fy + fz, 6);
		x0 = fx - t;
		y0 = fy - t;
		z0 = fz - t;
		if (x0 >= y0) begin
			if (y0 >= z0) begin
				a[1][0] = 1; a[2][0] = 1; a[2][1] = 1;
			end else if (x0 >= z0) begin
				a[1][0] = 1; a[2][0] = 1; a[2][2] = 1;
			end else begin
				a[1][2] = 1; a[2][0] = 1; a[2][2] = 1;
			end
		end else begin
			if (y0 < z0) begin
				a[1][2] = 1; a[2][1] = 1; a[2][2] = 1;
			end else if (x0 < z0) begin
				a[1][1] = 1; a[2][1] = 1; a[2][2] = 1;
			end else begin
				a[1][1] = 1; a[2][0] = 1; a[2][1] = 1;
			end
		end
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			xk = x0 - a[k][0] * 65536 + off[k];
			yk = y0 - a[k][1] * 65536 + off[k];
			zk = z0 - a[k][2] * 65536 + off[k];
			h = lookup((kc & 255) + a[k][2]);
			h = lookup((j & 255) + a[k][1] + h);
			h = lookup((i & 255) + a[k][0] + h) % 12;
			sum += corner(xk, yk, zk, g3x[h], g3y[h], g3z[h]);
		end
		return fdiv(sum * 32, 64'sd1 <<< 32);
	endfunction

	function void note_word(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		longint r;
		if (op == OP_WRITE) begin
			perm[idx] = val;
			return;
		end
		if (op == OP_NOISE_2D)
			r = noise_2d(x, y);
		else if (op == OP_NOISE_3D)
			r = noise_3d(x, y, z);
		else
			return;
		if (r > 131071)
			r = 131071;
		if (r < -131072)
			r = -131072;
		noise_q.push_back(r[17:0]);
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_noise(logic signed [17:0] got);
		logic signed [17:0] want;
		if (noise_q.size() == 0) begin
			report($sformatf("unexpected noise_value %0d", got));
			return;
		end
		want = noise_q.pop_front();
		if (got !== want)
			report($sformatf("noise_value %0d, expected %0d", got, want));
	endtask
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_WRITE;
	logic [7:0] table_index = '0;
	logic [7:0] table_value = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic signed [31:0] coord_z = '0;
	logic result_valid;
	logic signed [17:0] noise_value;

	noise_scoreboard sb = new();
	int quiet_cycles = 0;
	int gap_pct = 0;

	simplex_noise_2d_3d_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.table_index(table_index), .table_value(table_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.result_valid(result_valid), .noise_value(noise_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(op, table_index, table_value, coord_x, coord_y, coord_z);
			if (result_valid)
				sb.check_noise(noise_value);
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 5000) begin
				$display("timeout");
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task send_word(logic [1:0] o, logic [7:0] idx, logic [7:0] val,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		op = o;
		table_index = idx;
		table_value = val;
		coord_x = x;
		coord_y = y;
		coord_z = z;
		while (busy)
			@(negedge clk);
	endtask

	function logic signed [31:0] rand_coord();
		case ($urandom_range(4))
			0: return $urandom();
			1: return $signed($urandom_range(1048576)) - 524288;
			2: return ($signed($urandom_range(64)) - 32) <<< 16;
			3: return $signed($urandom_range(200)) - 100;
			default: return $signed($urandom_range(33554432)) - 16777216;
		endcase
	endfunction

	task send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			send_word(OP_WRITE, 8'($urandom()), 8'($urandom()), $urandom(), $urandom(),
				$urandom());
		else if (pick < 13)
			send_word(2'd3, 8'($urandom()), 8'($urandom()), $urandom(), $urandom(),
				$urandom());
		else if (pick < 56)
			send_word(OP_NOISE_2D, 8'($urandom()), 8'($urandom()), rand_coord(),
				rand_coord(), $urandom());
		else
			send_word(OP_NOISE_3D, 8'($urandom()), 8'($urandom()), rand_coord(),
				rand_coord(), rand_coord());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole table before any lookup
		for (int n = 0; n < 256; n++)
			send_word(OP_WRITE, 8'(n),
				(n == 0) ? 8'd255 : (n == 255) ? 8'd0 : 8'($urandom()), 0, 0, 0);

		send_word(OP_NOISE_2D, 8'd0, 8'd0, 0, 0, 0);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, 0, 0, 0);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, 32'h7fffffff, 32'h7fffffff, 0);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, 32'h80000000, 32'h80000000, 0);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, 32'h80000000, 32'h7fffffff, 0);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, -65536, -131072, 0);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, -65536, 65536, -196608);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, -1, -1, 0);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, -1, 1, -1);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, 32768, 16384, 0);
		send_word(OP_NOISE_3D, 8'd0, 8'd0, 21845, 10923, 32768);
		send_word(2'd3, 8'hff, 8'hff, -1, -1, -1);
		send_word(OP_WRITE, 8'hff, 8'hff, 0, 0, 0);
		send_word(OP_NOISE_2D, 8'd0, 8'd0, 32'h00ff0000, 32'h00ff0000, 0);

		gap_pct = 6;
		repeat (210) send_random();
		gap_pct = 85;
		repeat (210) send_random();
		gap_pct = 0;
		repeat (210) send_random();

		@(negedge clk);
		start = 1'b0;
		while (sb.noise_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* filelist.f */
hw/rtl/snd_pkg.sv
hw/rtl/snd_ram.sv
hw/rtl/snd_corner.sv
hw/rtl/simplex_noise_2d_3d_unit.sv
test/tb_top.sv
